// ----- sv/bsdp_pkg.sv -----
// ----------------------------------------------------------------------------
// bsdp_pkg
// Widths, limits, register codes and shared types of the block-scaled
// 4-bit dot product engine.
// ----------------------------------------------------------------------------
package bsdp_pkg;

  localparam int LANES      = 4;
  localparam int MAX_ROW    = 4096;
  localparam int MAX_BLOCK  = 256;

  localparam int ACT_W      = 16;
  localparam int WT_W       = 4;
  localparam int SCALE_W    = 16;
  localparam int PROD_W     = ACT_W + WT_W;
  localparam int SUM_W      = PROD_W + $clog2(LANES);
  localparam int PART_W     = 28;
  localparam int MULT_W     = PART_W + SCALE_W + 1;
  localparam int TOT_W      = 48;

  localparam int ROW_W      = 13;
  localparam int BLK_W      = 9;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;

  typedef logic signed [ACT_W-1:0]   act_t;
  typedef logic signed [WT_W-1:0]    wt_t;
  typedef logic        [SCALE_W-1:0] scale_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [SUM_W-1:0]   lsum_t;
  typedef logic signed [PART_W-1:0]  part_t;
  typedef logic signed [MULT_W-1:0]  mult_t;
  typedef logic signed [TOT_W-1:0]   total_t;
  typedef logic        [ROW_W-1:0]   row_cnt_t;
  typedef logic        [BLK_W-1:0]   blk_cnt_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_LENGTH = 1'b0,
    REG_BLOCK_SIZE = 1'b1
  } cfg_reg_t;

  localparam row_cnt_t ROW_RESET   = row_cnt_t'(64);
  localparam blk_cnt_t BLK_RESET   = blk_cnt_t'(32);
  localparam row_cnt_t ROW_LIM_MAX = row_cnt_t'(MAX_ROW);
  localparam blk_cnt_t BLK_LIM_MAX = blk_cnt_t'(MAX_BLOCK);
  localparam row_cnt_t ROW_STEP    = row_cnt_t'(LANES);
  localparam blk_cnt_t BLK_STEP    = blk_cnt_t'(LANES);

  localparam part_t  PART_MAX = {1'b0, {(PART_W-1){1'b1}}};
  localparam part_t  PART_MIN = {1'b1, {(PART_W-1){1'b0}}};
  localparam total_t TOT_MAX  = {1'b0, {(TOT_W-1){1'b1}}};
  localparam total_t TOT_MIN  = {1'b1, {(TOT_W-1){1'b0}}};

  // Per-item control leaving the counter stage
  typedef struct packed {
    logic valid;
    logic first;    // first word of a block: capture scale
    logic blk_end;  // block or row closes on this word
    logic row_end;
  } item_ctl_t;

  // Control that travels with a block flush
  typedef struct packed {
    logic valid;
    logic row_end;
  } flush_ctl_t;

endpackage

// ----- sv/bsdp_if.sv -----
// ----------------------------------------------------------------------------
// bsdp_in_if / bsdp_out_if
// Valid/ready channels of the dot product engine.
// ----------------------------------------------------------------------------
interface bsdp_in_if;
  import bsdp_pkg::*;

  logic   valid;
  logic   ready;
  act_t   act0;
  act_t   act1;
  act_t   act2;
  act_t   act3;
  wt_t    wt0;
  wt_t    wt1;
  wt_t    wt2;
  wt_t    wt3;
  scale_t scale;

  modport source (output valid, act0, act1, act2, act3, wt0, wt1, wt2, wt3, scale,
                  input ready);
  modport sink   (input valid, act0, act1, act2, act3, wt0, wt1, wt2, wt3, scale,
                  output ready);
endinterface

interface bsdp_out_if;
  import bsdp_pkg::*;

  logic   valid;
  logic   ready;
  total_t dot_value;

  modport source (output valid, dot_value, input ready);
  modport sink   (input valid, dot_value, output ready);
endinterface

// ----- sv/block_scaled_int4_dot_product.sv -----
// ----------------------------------------------------------------------------
// block_scaled_int4_dot_product
// Four-lane block-scaled int4 dot product with 48-bit saturating total.
// ----------------------------------------------------------------------------
//  channel | dir | word
//  in_s    | in  | act0..act3 (Q7.8), wt0..wt3 (int4), scale (Q4.12)
//  out_m   | out | dot_value (signed, 20 fraction bits), one per row
//  cfg_*   | in  | index 0 row_length, index 1 blk_size
//
//  Takes one word per cycle; in_s.ready drops only while a finished word
//  waits in the output register and the next row result reaches the last
//  stage. After the row's last word is taken, a row result passes the lane
//  multiply, block accumulate, scale multiply and total accumulate stages.
//  Synchronous reset clears counters, sums and loads the default config.
// ----------------------------------------------------------------------------
module block_scaled_int4_dot_product (
  input  logic                            clk,
  input  logic                            rst_n,
  bsdp_in_if.sink                         in_s,
  bsdp_out_if.source                      out_m,
  input  logic                            cfg_we,
  input  logic [bsdp_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [bsdp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bsdp_pkg::*;

  logic       en;
  logic       acc;
  item_ctl_t  item_ctl;
  scale_t     item_scale;
  flush_ctl_t flush_ctl;
  mult_t      flush_mult;
  act_t       act_a  [LANES];
  wt_t        wt_a   [LANES];
  prod_t      prod_a [LANES];

  assign act_a[0] = in_s.act0;
  assign act_a[1] = in_s.act1;
  assign act_a[2] = in_s.act2;
  assign act_a[3] = in_s.act3;
  assign wt_a[0]  = in_s.wt0;
  assign wt_a[1]  = in_s.wt1;
  assign wt_a[2]  = in_s.wt2;
  assign wt_a[3]  = in_s.wt3;

  assign in_s.ready = en;
  assign acc        = in_s.valid && en;

  bsdp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .acc      (acc),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .scale    (in_s.scale),
    .ctl_r    (item_ctl),
    .scale_r  (item_scale)
  );

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    bsdp_lane u_lane (
      .clk    (clk),
      .en     (acc),
      .act    (act_a[g]),
      .wt     (wt_a[g]),
      .prod_r (prod_a[g])
    );
  end

  bsdp_merge u_merge (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .ctl_i   (item_ctl),
    .scale_i (item_scale),
    .prods_i (prod_a),
    .flush_r (flush_ctl),
    .mult_r  (flush_mult)
  );

  bsdp_accum u_accum (
    .clk     (clk),
    .rst_n   (rst_n),
    .flush_i (flush_ctl),
    .mult_i  (flush_mult),
    .en      (en),
    .out_m   (out_m)
  );

endmodule

// ----- sv/bsdp_lane.sv -----
// ----------------------------------------------------------------------------
// bsdp_lane
// One multiply lane: activation times 4-bit weight, registered.
// ----------------------------------------------------------------------------
module bsdp_lane (
  input  logic            clk,
  input  logic            en,
  input  bsdp_pkg::act_t  act,
  input  bsdp_pkg::wt_t   wt,
  output bsdp_pkg::prod_t prod_r
);
  import bsdp_pkg::*;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= PROD_W'(act) * PROD_W'(wt);
    end
  end

endmodule

// ----- sv/bsdp_ctrl.sv -----
// ----------------------------------------------------------------------------
// bsdp_ctrl
// Config registers, row and block counters, and the per-word end flags.
// ----------------------------------------------------------------------------
module bsdp_ctrl (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic                             acc,
  input  logic                             cfg_we,
  input  logic [bsdp_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [bsdp_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  bsdp_pkg::scale_t                 scale,
  output bsdp_pkg::item_ctl_t              ctl_r,
  output bsdp_pkg::scale_t                 scale_r
);
  import bsdp_pkg::*;

  row_cnt_t row_length_r;
  blk_cnt_t blk_size_r;
  row_cnt_t elem_cnt_r;
  blk_cnt_t blk_cnt_r;

  row_cnt_t row_lim;
  blk_cnt_t blk_lim;
  row_cnt_t elem_inc;
  blk_cnt_t blk_inc;
  logic     row_end;
  logic     blk_end;

  always_comb begin
    row_lim  = (row_length_r > ROW_LIM_MAX) ? ROW_LIM_MAX : row_length_r;
    blk_lim  = (blk_size_r > BLK_LIM_MAX) ? BLK_LIM_MAX : blk_size_r;
    elem_inc = elem_cnt_r + ROW_STEP;
    blk_inc  = blk_cnt_r + BLK_STEP;
    row_end  = (elem_inc >= row_lim);
    // a row end also closes the open block
    blk_end  = row_end || (blk_inc >= blk_lim);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_length_r <= ROW_RESET;
      blk_size_r   <= BLK_RESET;
      elem_cnt_r   <= '0;
      blk_cnt_r    <= '0;
      ctl_r        <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_idx))
          REG_ROW_LENGTH: row_length_r <= cfg_data[ROW_W-1:0];
          REG_BLOCK_SIZE: blk_size_r   <= cfg_data[BLK_W-1:0];
        endcase
      end
      if (en) begin
        ctl_r.valid <= acc;
        if (acc) begin
          ctl_r.first   <= (blk_cnt_r == '0);
          ctl_r.blk_end <= blk_end;
          ctl_r.row_end <= row_end;
          elem_cnt_r    <= row_end ? '0 : elem_inc;
          blk_cnt_r     <= blk_end ? '0 : blk_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && acc) begin
      scale_r <= scale;
    end
  end

endmodule

// ----- sv/bsdp_merge.sv -----
// ----------------------------------------------------------------------------
// bsdp_merge
// Sums the lane products into the block partial, holds the block scale and
// multiplies partial by scale when a block closes.
// ----------------------------------------------------------------------------
module bsdp_merge (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  bsdp_pkg::item_ctl_t  ctl_i,
  input  bsdp_pkg::scale_t     scale_i,
  input  bsdp_pkg::prod_t      prods_i [bsdp_pkg::LANES],
  output bsdp_pkg::flush_ctl_t flush_r,
  output bsdp_pkg::mult_t      mult_r
);
  import bsdp_pkg::*;

  part_t                partial_r;
  scale_t               held_scale_r;
  flush_ctl_t           b_ctl_r;
  part_t                b_part_r;
  scale_t               b_scale_r;

  lsum_t                lane_sum;
  logic signed [PART_W:0] part_sum;
  part_t                part_sat;
  scale_t               cur_scale;

  always_comb begin
    lane_sum = '0;
    for (int i = 0; i < LANES; i++) begin
      lane_sum = lane_sum + SUM_W'(prods_i[i]);
    end
    part_sum = (PART_W+1)'(partial_r) + (PART_W+1)'(lane_sum);
    if (part_sum[PART_W] != part_sum[PART_W-1]) begin
      part_sat = part_sum[PART_W] ? PART_MIN : PART_MAX;
    end else begin
      part_sat = part_sum[PART_W-1:0];
    end
    cur_scale = ctl_i.first ? scale_i : held_scale_r;
  end

  // block accumulate stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r    <= '0;
      held_scale_r <= '0;
      b_ctl_r      <= '0;
    end else if (en) begin
      b_ctl_r.valid   <= ctl_i.valid && ctl_i.blk_end;
      b_ctl_r.row_end <= ctl_i.row_end;
      if (ctl_i.valid) begin
        held_scale_r <= cur_scale;
        partial_r    <= ctl_i.blk_end ? '0 : part_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_part_r  <= part_sat;
      b_scale_r <= cur_scale;
    end
  end

  // scale multiply stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flush_r <= '0;
    end else if (en) begin
      flush_r <= b_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mult_r <= MULT_W'(b_part_r) * MULT_W'($signed({1'b0, b_scale_r}));
    end
  end

endmodule

// ----- sv/bsdp_accum.sv -----
// ----------------------------------------------------------------------------
// bsdp_accum
// Adds scaled block sums into the row total and holds the finished word
// in the output register.
// ----------------------------------------------------------------------------
module bsdp_accum (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bsdp_pkg::flush_ctl_t flush_i,
  input  bsdp_pkg::mult_t      mult_i,
  output logic                 en,
  bsdp_out_if.source           out_m
);
  import bsdp_pkg::*;

  total_t                total_r;
  logic                  out_valid_r;
  total_t                dot_value_r;

  logic signed [TOT_W:0] tot_sum;
  total_t                tot_sat;
  logic                  emit;

  always_comb begin
    tot_sum = (TOT_W+1)'(total_r) + (TOT_W+1)'(mult_i);
    if (tot_sum[TOT_W] != tot_sum[TOT_W-1]) begin
      tot_sat = tot_sum[TOT_W] ? TOT_MIN : TOT_MAX;
    end else begin
      tot_sat = tot_sum[TOT_W-1:0];
    end
    // hold the whole pipe only when a new word meets an untaken one
    en   = !(out_valid_r && !out_m.ready && flush_i.valid && flush_i.row_end);
    emit = en && flush_i.valid && flush_i.row_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (en && flush_i.valid) begin
        total_r <= flush_i.row_end ? '0 : tot_sat;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_m.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      dot_value_r <= tot_sat;
    end
  end

  assign out_m.valid     = out_valid_r;
  assign out_m.dot_value = dot_value_r;

endmodule

// ----- sv/bsdp_checker.sv -----
// ----------------------------------------------------------------------------
// bsdp_checker
// Port-level checks of the dot product engine, bound to the top level.
// ----------------------------------------------------------------------------
module bsdp_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input bsdp_pkg::total_t      dot_value
);
  import bsdp_pkg::*;

  // an untaken result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(dot_value))
    else $error("result word changed while stalled");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // input only stalls behind a waiting result word
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_valid && !out_ready) |-> in_ready)
    else $error("input stalled with free output");

  // an input word only stalls while a result word waits untaken
  a_no_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output backpressure");

endmodule

bind block_scaled_int4_dot_product bsdp_checker u_bsdp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_s.valid),
  .in_ready  (in_s.ready),
  .out_valid (out_m.valid),
  .out_ready (out_m.ready),
  .dot_value (out_m.dot_value)
);
